### sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the 3x3 edge-clamped box blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

	// default line store depth
	localparam int MAX_WIDTH_DEF = 1024;
	// largest supported frame height
	localparam int MAX_HEIGHT = 4096;

	// register file
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int LW_W       = 11;
	localparam int FH_W       = 13;
	localparam int LINE_WIDTH_RST   = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// row counter width, rows < MAX_HEIGHT
	localparam int ROW_W = 12;
	// channel sum width, 9 * 255 fits
	localparam int SUM_W = 12;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// which window rows/columns fall outside the frame
	typedef struct packed {
		logic top_out;
		logic bot_out;
		logic lft_out;
		logic rgt_out;
	} border_t;

	// per-word control travelling with the pipeline
	typedef struct packed {
		logic    push;
		logic    emit;
		logic    last;
		border_t bord;
	} ctrl_t;

	// number of pixels averaged
	typedef enum logic [1:0] {
		CNT4,
		CNT6,
		CNT9
	} cnt_t;

	typedef struct packed {
		logic valid;
		logic last;
		cnt_t cnt;
	} res_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sum3_t;

endpackage

`default_nettype wire

### sv/box_blur_3x3_edge_clamped_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clamped_core
// 3x3 box blur over a raster RGB888 stream with frame-edge clamping.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result per clock when out_ready
// stays high. A word's result reaches the output through four register stages:
// line memory read, window shift, masked adder tree, then reciprocal multiply
// into the output register; the stages advance together and stop only while
// a result waits at the output. Results trail their pixels by one row and
// one column; after the last pixel of a frame send line_width+1 drain words
// (req_type = 1) to flush the rest, the last result carries frame_end.
// Pixels sent while draining and drain words with nothing owed are dropped.
// A register write restarts the frame and must be done with the pipeline
// empty. The line memories need no clearing after reset.
`default_nettype none

module box_blur_3x3_edge_clamped_core import bbc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  req_type,
	input  wire logic [7:0]            in_red,
	input  wire logic [7:0]            in_green,
	input  wire logic [7:0]            in_blue,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_blue,
	output logic                       frame_end,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          adv, acc;
	logic [CW-1:0] rd_addr;
	ctrl_t         ctl_s1;
	pixel_t        in_pix, pix_s1, up1_s1, up2_s1, pix_q;
	res_ctl_t      rc_s3;
	sum3_t         sum_s3;
	logic          out_valid_q, frame_end_q;

	// whole pipeline moves unless a result is stuck at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && adv;
	// drain words push a zero column
	assign in_pix   = req_type ? '0 : pixel_t'{red: in_red, green: in_green, blue: in_blue};

	bbc_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.acc      (acc),
		.req_type (req_type),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rd_addr  (rd_addr),
		.ctl_s1   (ctl_s1)
	);

	bbc_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.adv    (adv),
		.rd_addr(rd_addr),
		.in_pix (in_pix),
		.push_s1(ctl_s1.push),
		.pix_s1 (pix_s1),
		.up1_s1 (up1_s1),
		.up2_s1 (up2_s1)
	);

	bbc_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.ctl_s1(ctl_s1),
		.pix_s1(pix_s1),
		.up1_s1(up1_s1),
		.up2_s1(up2_s1),
		.rc_s3 (rc_s3),
		.sum_s3(sum_s3)
	);

	bbc_avg u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.rc_s3      (rc_s3),
		.sum_s3     (sum_s3),
		.out_valid_q(out_valid_q),
		.pix_q      (pix_q),
		.frame_end_q(frame_end_q)
	);

	assign out_valid = out_valid_q;
	assign out_red   = pix_q.red;
	assign out_green = pix_q.green;
	assign out_blue  = pix_q.blue;
	assign frame_end = frame_end_q;

endmodule

`default_nettype wire

### sv/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl
// Configuration registers, raster position counters and drain counter.
// Decides per word whether it pushes a column, whether it yields a result
// and which window borders lie outside the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ctrl import bbc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          acc,
	input  wire logic                          req_type,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	output logic      [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	output ctrl_t                              ctl_s1
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DW = $clog2(MAX_WIDTH + 2);
	localparam int RST_W = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;

	logic [CW-1:0]    wm1_q, wm1_d;
	logic [ROW_W-1:0] hm1_q, hm1_d;
	logic [CW-1:0]    col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [DW-1:0]    drain_q, drain_d;

	logic [31:0]   lw, lw_sat, fh, fh_sat;
	logic [DW-1:0] w_c, w_p1;
	logic          col0, col_last, row_last, owed, act, is_pix;
	logic          drain_first, drain_one, pix_emit, emit_c, last_c;
	border_t       bd;

	assign rd_addr = col_q;

	// clamp register writes to the supported range
	always_comb begin
		lw = 32'(cfg_data[LW_W-1:0]);
		fh = 32'(cfg_data[FH_W-1:0]);
		if (lw < 32'd2) begin
			lw_sat = 32'd2;
		end else if (lw > 32'(MAX_WIDTH)) begin
			lw_sat = 32'(MAX_WIDTH);
		end else begin
			lw_sat = lw;
		end
		if (fh < 32'd2) begin
			fh_sat = 32'd2;
		end else if (fh > 32'(MAX_HEIGHT)) begin
			fh_sat = 32'(MAX_HEIGHT);
		end else begin
			fh_sat = fh;
		end
	end

	// position flags for the word at the input
	always_comb begin
		w_c         = DW'(wm1_q) + DW'(1);
		w_p1        = DW'(wm1_q) + DW'(2);
		is_pix      = !req_type;
		col0        = (col_q == '0);
		col_last    = (col_q == wm1_q);
		row_last    = (row_q == hm1_q);
		owed        = (drain_q != '0);
		act         = is_pix ? !owed : owed;
		drain_first = (drain_q == w_p1);
		drain_one   = (drain_q == DW'(1));
		pix_emit    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !col0);
		emit_c      = act && (is_pix ? pix_emit : 1'b1);
		last_c      = act && !is_pix && drain_one;
		bd          = '0;
		if (is_pix) begin
			if (col0) begin
				// result for the last column of the row two up
				bd.top_out = (row_q == ROW_W'(2));
				bd.rgt_out = 1'b1;
			end else begin
				bd.top_out = (row_q == ROW_W'(1));
				bd.lft_out = (col_q == CW'(1));
			end
		end else if (drain_first) begin
			// last pixel of the next-to-last row
			bd.top_out = (hm1_q == ROW_W'(1));
			bd.rgt_out = 1'b1;
		end else begin
			// bottom row
			bd.bot_out = 1'b1;
			bd.lft_out = (drain_q == w_c);
			bd.rgt_out = drain_one;
		end
	end

	// next state of counters and registers
	always_comb begin
		wm1_d   = wm1_q;
		hm1_d   = hm1_q;
		col_d   = col_q;
		row_d   = row_q;
		drain_d = drain_q;
		if (cfg_we) begin
			col_d   = '0;
			row_d   = '0;
			drain_d = '0;
			unique case (cfg_index)
				REG_LINE_WIDTH:   wm1_d = CW'(lw_sat - 32'd1);
				REG_FRAME_HEIGHT: hm1_d = ROW_W'(fh_sat - 32'd1);
			endcase
		end else if (acc && act) begin
			if (is_pix) begin
				if (row_last && col_last) begin
					col_d   = '0;
					row_d   = '0;
					drain_d = w_p1;
				end else if (col_last) begin
					col_d = '0;
					row_d = row_q + ROW_W'(1);
				end else begin
					col_d = col_q + CW'(1);
				end
			end else begin
				col_d   = col_last ? '0 : col_q + CW'(1);
				drain_d = drain_q - DW'(1);
				if (drain_one) begin
					col_d = '0;
					row_d = '0;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q   <= CW'(RST_W - 1);
			hm1_q   <= ROW_W'(FRAME_HEIGHT_RST - 1);
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			wm1_q   <= wm1_d;
			hm1_q   <= hm1_d;
			col_q   <= col_d;
			row_q   <= row_d;
			drain_q <= drain_d;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.push <= acc && act;
			ctl_s1.emit <= acc && emit_c;
			ctl_s1.last <= acc && last_c;
			ctl_s1.bord <= bd;
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wm1_q)
		else $error("column counter beyond line width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= hm1_q)
		else $error("row counter beyond frame height");

	a_drain_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q != '0) |-> (row_q == '0 && drain_q <= w_p1))
		else $error("drain count inconsistent with position");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type && drain_q == DW'(1) && !cfg_we)
			|=> (drain_q == '0 && col_q == '0 && ctl_s1.last))
		else $error("frame end did not restart the frame");

endmodule

`default_nettype wire

### sv/bbc_line_buf.sv
// ----------------------------------------------------------------------------
// bbc_line_buf
// Two line memories holding the rows one and two above the incoming one.
// Read at stage 0 into registers, rotated and written back at stage 1,
// with a bypass when the next word reads the column being written.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_line_buf import bbc_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         adv,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  wire pixel_t                       in_pix,
	input  wire logic                         push_s1,
	output pixel_t                            pix_s1,
	output pixel_t                            up1_s1,
	output pixel_t                            up2_s1
);

	localparam int CW = $clog2(MAX_WIDTH);

	pixel_t        mem_a [MAX_WIDTH];
	pixel_t        mem_b [MAX_WIDTH];
	logic [CW-1:0] addr_s1;

	// write back the rotated column, read the next one
	always_ff @(posedge clk) begin
		if (adv) begin
			if (push_s1) begin
				mem_a[addr_s1] <= pix_s1;
				mem_b[addr_s1] <= up1_s1;
			end
			if (push_s1 && (addr_s1 == rd_addr)) begin
				up1_s1 <= pix_s1;
				up2_s1 <= up1_s1;
			end else begin
				up1_s1 <= mem_a[rd_addr];
				up2_s1 <= mem_b[rd_addr];
			end
			pix_s1  <= in_pix;
			addr_s1 <= rd_addr;
		end
	end

endmodule

`default_nettype wire

### sv/bbc_window.sv
// ----------------------------------------------------------------------------
// bbc_window
// 3x3 neighbourhood shift register and masked channel sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_window import bbc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire ctrl_t  ctl_s1,
	input  wire pixel_t pix_s1,
	input  wire pixel_t up1_s1,
	input  wire pixel_t up2_s1,
	output res_ctl_t    rc_s3,
	output sum3_t       sum_s3
);

	pixel_t            win_q [3][3];
	ctrl_t             ctl_s2;
	logic [2:0][2:0][7:0] rv, gv, bv;
	logic [2:0]        rin, cin;
	sum3_t             sum_c;
	cnt_t              cnt_c;

	// masked sum of a 3x3 block, row sums first
	function automatic logic [SUM_W-1:0] sum9(input logic [2:0][2:0][7:0] v,
			input logic [2:0] rmask, input logic [2:0] cmask);
		logic [SUM_W-1:0] acc;
		logic [9:0]       rs;
		acc = '0;
		for (int r = 0; r < 3; r++) begin
			rs = '0;
			for (int c = 0; c < 3; c++) begin
				if (cmask[c]) begin
					rs = rs + 10'(v[r][c]);
				end
			end
			if (rmask[r]) begin
				acc = acc + SUM_W'(rs);
			end
		end
		return acc;
	endfunction

	// shift a new column in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv && ctl_s1.push) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up2_s1;
			win_q[1][2] <= up1_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	// sums over the in-frame part of the window
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				rv[r][c] = win_q[r][c].red;
				gv[r][c] = win_q[r][c].green;
				bv[r][c] = win_q[r][c].blue;
			end
		end
		rin = {!ctl_s2.bord.bot_out, 1'b1, !ctl_s2.bord.top_out};
		cin = {!ctl_s2.bord.rgt_out, 1'b1, !ctl_s2.bord.lft_out};
		sum_c.red   = sum9(rv, rin, cin);
		sum_c.green = sum9(gv, rin, cin);
		sum_c.blue  = sum9(bv, rin, cin);
		if ((rin != 3'b111) && (cin != 3'b111)) begin
			cnt_c = CNT4;
		end else if ((rin == 3'b111) && (cin == 3'b111)) begin
			cnt_c = CNT9;
		end else begin
			cnt_c = CNT6;
		end
	end

	// stage 2 and 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			rc_s3  <= '0;
		end else if (adv) begin
			ctl_s2      <= ctl_s1;
			rc_s3.valid <= ctl_s2.emit;
			rc_s3.last  <= ctl_s2.last;
			rc_s3.cnt   <= cnt_c;
		end
	end

	// stage 3 sums
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum_c;
		end
	end

endmodule

`default_nettype wire

### sv/bbc_avg.sv
// ----------------------------------------------------------------------------
// bbc_avg
// Rounded division of the channel sums by 4, 6 or 9 and the output register.
// Division by 6 and 9 is a multiply by a 16-bit reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_avg import bbc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire res_ctl_t rc_s3,
	input  wire sum3_t    sum_s3,
	output logic          out_valid_q,
	output pixel_t        pix_q,
	output logic          frame_end_q
);

	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_6 = (1 << RECIP_SHIFT) / 6 + 1;
	localparam int RECIP_9 = (1 << RECIP_SHIFT) / 9 + 1;
	localparam int PROD_W = 27;

	pixel_t pix_c;

	// (2*sum + n) / (2*n) reduces to (sum + n/2 rounded down) / n
	function automatic logic [7:0] avg_chan(input logic [SUM_W-1:0] s, input cnt_t c);
		logic [SUM_W:0]    x;
		logic [PROD_W-1:0] p;
		unique case (c)
			CNT4: begin
				x = (SUM_W+1)'(s) + (SUM_W+1)'(2);
				p = PROD_W'(x) << (RECIP_SHIFT - 2);
			end
			CNT6: begin
				x = (SUM_W+1)'(s) + (SUM_W+1)'(3);
				p = PROD_W'(x) * PROD_W'(RECIP_6);
			end
			// nine-pixel window
			default: begin
				x = (SUM_W+1)'(s) + (SUM_W+1)'(4);
				p = PROD_W'(x) * PROD_W'(RECIP_9);
			end
		endcase
		return p[RECIP_SHIFT +: 8];
	endfunction

	always_comb begin
		pix_c.red   = avg_chan(sum_s3.red, rc_s3.cnt);
		pix_c.green = avg_chan(sum_s3.green, rc_s3.cnt);
		pix_c.blue  = avg_chan(sum_s3.blue, rc_s3.cnt);
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rc_s3.valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q       <= pix_c;
			frame_end_q <= rc_s3.last;
		end
	end

endmodule

`default_nettype wire
